[hdl/assert_macros.svh]
// assertion helpers used by the top level to check itself
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must be followed by a consequence in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/vdh_pkg.sv]
package vdh_pkg;

    // default widths of the sample fields and of the tick counter
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 24;

    // fixed register and result widths
    localparam int THRESH_W   = 18;
    localparam int TICKS_W    = 24;
    localparam int VAR_W      = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // largest value the variation field can show
    localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

    // register reset values
    localparam logic [THRESH_W-1:0] THRESHOLD_RST     = THRESH_W'(4000);
    localparam logic [TICKS_W-1:0]  LED_TICKS_RST     = TICKS_W'(3000000);
    localparam logic [TICKS_W-1:0]  HOLDOFF_TICKS_RST = TICKS_W'(8000000);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LED_TICKS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_TICKS = 2'd2;

    // detector phase
    typedef enum logic [1:0] {
        PH_NEED_REF = 2'd0,
        PH_COMPARE  = 2'd1,
        PH_LED_ON   = 2'd2,
        PH_HOLDOFF  = 2'd3
    } phase_t;

    // what the merge stage reports to the control logic
    typedef struct packed {
        logic             over;
        logic [VAR_W-1:0] variation;
    } merge_t;

endpackage

[hdl/vdh_lane.sv]
module vdh_lane #(
    parameter int SAMPLE_BITS = vdh_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SAMPLE_BITS-1:0] ref_val,
    output logic        [SAMPLE_BITS-1:0] abs_diff
);

    logic signed [SAMPLE_BITS:0] diff;
    logic signed [SAMPLE_BITS:0] mag;

    // one extra bit keeps the difference exact
    assign diff = {sample[SAMPLE_BITS-1], sample} - {ref_val[SAMPLE_BITS-1], ref_val};

    // magnitude never exceeds 2^SAMPLE_BITS - 1
    assign mag      = diff[SAMPLE_BITS] ? -diff : diff;
    assign abs_diff = mag[SAMPLE_BITS-1:0];

endmodule

[hdl/vdh_merge.sv]
module vdh_merge #(
    parameter int SAMPLE_BITS = vdh_pkg::SAMPLE_BITS_DEF
) (
    input  logic [SAMPLE_BITS-1:0]       diff_x,
    input  logic [SAMPLE_BITS-1:0]       diff_y,
    input  logic [SAMPLE_BITS-1:0]       diff_z,
    input  logic [vdh_pkg::THRESH_W-1:0] threshold,
    output vdh_pkg::merge_t              result
);

    localparam int SUM_W = SAMPLE_BITS + 2;
    localparam int CMP_W = (SUM_W > vdh_pkg::VAR_W) ? SUM_W : vdh_pkg::VAR_W;

    logic [SUM_W-1:0] sum;
    logic [CMP_W-1:0] sum_w;
    logic [CMP_W-1:0] thresh_w;
    logic [CMP_W-1:0] max_w;

    // add the three lane magnitudes
    assign sum = SUM_W'(diff_x) + SUM_W'(diff_y) + SUM_W'(diff_z);

    // full precision compare against threshold
    assign sum_w         = CMP_W'(sum);
    assign thresh_w      = CMP_W'(threshold);
    assign max_w         = CMP_W'(vdh_pkg::VAR_MAX);
    assign result.over   = sum_w > thresh_w;

    // saturate to the result field
    assign result.variation = (sum_w > max_w) ? vdh_pkg::VAR_MAX
                                              : sum_w[vdh_pkg::VAR_W-1:0];

endmodule

[hdl/vibration_detector_with_holdoff_top.sv]
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+---------------------------------
// in       | input     | in_valid / in_ready   | mode, accel_x, accel_y, accel_z
// out      | output    | out_valid / out_ready | led, detected, variation
// cfg      | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item per cycle while in_ready is high; results are registered in the buffer
// the three axis lanes, merge and phase update all settle in the accepting cycle
// a two-entry output buffer keeps in_ready high while one result waits
// cfg_ready is always high; writes are registered
// reset: phase needs a reference, counters and references zero, registers at defaults
`include "assert_macros.svh"

module vibration_detector_with_holdoff_top #(
    parameter int SAMPLE_BITS = vdh_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = vdh_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic signed [SAMPLE_BITS-1:0]   accel_x,
    input  logic signed [SAMPLE_BITS-1:0]   accel_y,
    input  logic signed [SAMPLE_BITS-1:0]   accel_z,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            led,
    output logic                            detected,
    output logic [vdh_pkg::VAR_W-1:0]       variation,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vdh_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [vdh_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // configuration registers
    logic [vdh_pkg::THRESH_W-1:0] threshold_reg;
    logic [vdh_pkg::TICKS_W-1:0]  led_ticks_reg;
    logic [vdh_pkg::TICKS_W-1:0]  holdoff_ticks_reg;

    // detector state
    vdh_pkg::phase_t               phase_reg;
    vdh_pkg::phase_t               phase_next;
    logic [COUNT_BITS-1:0]         tick_count_reg;
    logic [COUNT_BITS-1:0]         tick_count_next;
    logic signed [SAMPLE_BITS-1:0] ref_x_reg;
    logic signed [SAMPLE_BITS-1:0] ref_y_reg;
    logic signed [SAMPLE_BITS-1:0] ref_z_reg;

    // output buffer
    logic                         out_valid_reg;
    logic                         out_led_reg;
    logic                         out_detected_reg;
    logic [vdh_pkg::VAR_W-1:0]    out_variation_reg;
    logic                         skid_valid_reg;
    logic                         skid_led_reg;
    logic                         skid_detected_reg;
    logic [vdh_pkg::VAR_W-1:0]    skid_variation_reg;

    logic                      in_fire;
    logic                      ref_load;
    logic                      detect;
    logic                      compare;
    logic [COUNT_BITS-1:0]     led_load;
    logic [COUNT_BITS-1:0]     hold_load;
    logic [SAMPLE_BITS-1:0]    diff_x;
    logic [SAMPLE_BITS-1:0]    diff_y;
    logic [SAMPLE_BITS-1:0]    diff_z;
    vdh_pkg::merge_t           merge;
    logic                      res_led;
    logic                      res_detected;
    logic [vdh_pkg::VAR_W-1:0] res_variation;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= vdh_pkg::THRESHOLD_RST;
            led_ticks_reg     <= vdh_pkg::LED_TICKS_RST;
            holdoff_ticks_reg <= vdh_pkg::HOLDOFF_TICKS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                vdh_pkg::REG_THRESHOLD:     threshold_reg     <= cfg_data[vdh_pkg::THRESH_W-1:0];
                vdh_pkg::REG_LED_TICKS:     led_ticks_reg     <= cfg_data[vdh_pkg::TICKS_W-1:0];
                vdh_pkg::REG_HOLDOFF_TICKS: holdoff_ticks_reg <= cfg_data[vdh_pkg::TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    // per-axis lanes
    vdh_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
        .sample   (accel_x),
        .ref_val  (ref_x_reg),
        .abs_diff (diff_x)
    );

    vdh_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
        .sample   (accel_y),
        .ref_val  (ref_y_reg),
        .abs_diff (diff_y)
    );

    vdh_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
        .sample   (accel_z),
        .ref_val  (ref_z_reg),
        .abs_diff (diff_z)
    );

    // combine lanes and test against threshold
    vdh_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
        .diff_x    (diff_x),
        .diff_y    (diff_y),
        .diff_z    (diff_z),
        .threshold (threshold_reg),
        .result    (merge)
    );

    // durations as loaded into the counter
    assign led_load  = COUNT_BITS'(led_ticks_reg);
    assign hold_load = COUNT_BITS'(holdoff_ticks_reg);

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        ref_load        = 1'b0;
        detect          = 1'b0;
        compare         = 1'b0;
        if (in_fire)
        begin
            if (mode)
            begin
                // tick only counts inside the led or holdoff period
                if (phase_reg inside {vdh_pkg::PH_LED_ON, vdh_pkg::PH_HOLDOFF})
                begin
                    tick_count_next = tick_count_reg - COUNT_ONE;
                    if (tick_count_reg == COUNT_ONE)
                    begin
                        if (phase_reg == vdh_pkg::PH_LED_ON)
                        begin
                            tick_count_next = hold_load;
                            phase_next = (hold_load == '0) ? vdh_pkg::PH_NEED_REF
                                                           : vdh_pkg::PH_HOLDOFF;
                        end
                        else
                        begin
                            phase_next = vdh_pkg::PH_NEED_REF;
                        end
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    vdh_pkg::PH_NEED_REF:
                    begin
                        ref_load   = 1'b1;
                        phase_next = vdh_pkg::PH_COMPARE;
                    end
                    vdh_pkg::PH_COMPARE:
                    begin
                        compare = 1'b1;
                        if (merge.over)
                        begin
                            detect = 1'b1;
                            if (led_load != '0)
                            begin
                                tick_count_next = led_load;
                                phase_next      = vdh_pkg::PH_LED_ON;
                            end
                            else
                            begin
                                tick_count_next = hold_load;
                                phase_next = (hold_load == '0) ? vdh_pkg::PH_NEED_REF
                                                               : vdh_pkg::PH_HOLDOFF;
                            end
                        end
                        else
                        begin
                            ref_load = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result of the accepted item
    always_comb
    begin
        res_led       = (phase_next == vdh_pkg::PH_LED_ON);
        res_detected  = detect;
        res_variation = compare ? merge.variation : '0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= vdh_pkg::PH_NEED_REF;
            tick_count_reg <= '0;
            ref_x_reg      <= '0;
            ref_y_reg      <= '0;
            ref_z_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            if (ref_load)
            begin
                ref_x_reg <= accel_x;
                ref_y_reg <= accel_y;
                ref_z_reg <= accel_z;
            end
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload of the output buffer
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_led_reg       <= skid_led_reg;
                out_detected_reg  <= skid_detected_reg;
                out_variation_reg <= skid_variation_reg;
            end
            else if (in_fire)
            begin
                out_led_reg       <= res_led;
                out_detected_reg  <= res_detected;
                out_variation_reg <= res_variation;
            end
        end
        else if (in_fire)
        begin
            skid_led_reg       <= res_led;
            skid_detected_reg  <= res_detected;
            skid_variation_reg <= res_variation;
        end
    end

    assign out_valid = out_valid_reg;
    assign led       = out_led_reg;
    assign detected  = out_detected_reg;
    assign variation = out_variation_reg;

    // checks
    `ASSERT_CLK(a_skid_needs_out, skid_valid_reg |-> out_valid_reg, "skid entry without output entry")
    `ASSERT_CLK(a_count_live, (phase_reg == vdh_pkg::PH_LED_ON || phase_reg == vdh_pkg::PH_HOLDOFF) |-> (tick_count_reg != '0), "zero count in timed phase")
    `ASSERT_CLK(a_detect_var, (out_valid_reg && out_detected_reg) |-> (out_variation_reg != '0), "detection with zero variation")
    `ASSERT_NEXT(a_ref_taken, in_fire && !mode && phase_reg == vdh_pkg::PH_NEED_REF, phase_reg == vdh_pkg::PH_COMPARE, "reference sample did not arm compare")

endmodule
